@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CSVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/csvt_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Item types, byte classes, parser phases and character codes.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam logic [9:0] SPACES_MAX = 10'd1023;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_EOS  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CELL_LEN = 2'd1,
    ERR_COLUMNS  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_LINE    = 3'd0,
    PH_COMMENT = 3'd1,
    PH_START   = 3'd2,
    PH_PLAIN   = 3'd3,
    PH_QUOTED  = 3'd4,
    PH_ESCAPE  = 3'd5,
    PH_AFTERQ  = 3'd6
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data_byte;
    logic [9:0]  spaces_before;
    logic        end_cell;
    logic        end_row;
    logic        header_row;
    logic [8:0]  cell_count;
    logic [31:0] line_number;
    logic [1:0]  error_code;
    logic        stream_done;
  } out_item_t;

  typedef struct packed {
    logic       eos;
    logic       is_nl;
    logic       is_comma;
    logic       is_space;
    logic       is_quote;
    logic       is_hash;
    logic       is_bslash;
    logic [7:0] text_byte;
  } token_t;

endpackage

@@ src/csv_row_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// CSV row tokenizer core
// Byte-serial CSV tokenizer reporting cell bytes, cell ends and row ends.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload     Handshake
// in       in   in_item_i   in_valid_i / in_stall_o
// out      out  out_item_o  out_valid_o / out_stall_i
//
// One byte per cycle while the output is not stalled; a result passes through the token queue and the result register.
// The rate is set by the parser state machine, which takes one token a cycle unless the output stalls.
// A two-entry token queue sits between the classifier and the parser.
// Reset clears the parser, counters and queue; no clearing pass is needed.
// in_stall_o is high only while the queue is full.
// ----------------------------------------------------------------------------
module csv_row_tokenizer_core #(
  parameter int unsigned MAX_CELL_LEN = 1024,
  parameter int unsigned MAX_COLUMNS  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csvt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvt_pkg::out_item_t out_item_o
);

  csvt_pkg::token_t tok_in, tok_head;
  logic             q_full, q_valid, q_pop;

  assign in_stall_o = q_full;

  csvt_front u_front (
    .item_i  (in_item_i),
    .token_o (tok_in)
  );

  csvt_queue #(
    .DEPTH (csvt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (tok_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (tok_head)
  );

  csvt_back #(
    .MAX_CELL_LEN (MAX_CELL_LEN),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (tok_head),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ src/csvt_front.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer front end
// Classifies each input item, byte or stream end, into the token that the back end parses.
// ----------------------------------------------------------------------------
module csvt_front (
  input  csvt_pkg::in_item_t item_i,
  output csvt_pkg::token_t   token_o
);

  logic is_byte;

  assign is_byte = (item_i.op == csvt_pkg::OP_BYTE);

  always_comb begin
    token_o.eos       = !is_byte;
    token_o.is_nl     = is_byte && (item_i.text_byte == csvt_pkg::CHAR_NL);
    token_o.is_comma  = is_byte && (item_i.text_byte == csvt_pkg::CHAR_COMMA);
    token_o.is_space  = is_byte && (item_i.text_byte == csvt_pkg::CHAR_SPACE);
    token_o.is_quote  = is_byte && (item_i.text_byte == csvt_pkg::CHAR_QUOTE);
    token_o.is_hash   = is_byte && (item_i.text_byte == csvt_pkg::CHAR_HASH);
    token_o.is_bslash = is_byte && (item_i.text_byte == csvt_pkg::CHAR_BSLASH);
    token_o.text_byte = item_i.text_byte;
  end

endmodule

@@ src/csvt_queue.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer token queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module csvt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  csvt_pkg::token_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output csvt_pkg::token_t  data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  csvt_pkg::token_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/csvt_back.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer back end
// Parser state machine, cell and row counters, and the result register.
// ----------------------------------------------------------------------------
module csvt_back #(
  parameter int unsigned MAX_CELL_LEN = 1024,
  parameter int unsigned MAX_COLUMNS  = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  input  csvt_pkg::token_t    tok_i,
  output logic                tok_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvt_pkg::out_item_t out_item_o
);

  localparam int unsigned LEN_W = $clog2(MAX_CELL_LEN + 2);
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 1);

  csvt_pkg::phase_e phase_q, phase_d;
  logic [LEN_W-1:0] pend_q, pend_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [COL_W-1:0] cells_q, cells_d;
  logic [COL_W-1:0] hdr_cols_q, hdr_cols_d;
  logic             hdr_done_q, hdr_done_d;
  logic             sac_q, sac_d;
  logic [31:0]      lines_q, lines_d;
  logic [1:0]       err_q, err_d;
  logic             out_valid_q, out_valid_d;
  csvt_pkg::out_item_t out_item_q, out_item_d;

  logic fire;
  logic start_byte, sac_set, sac_clr;
  logic do_content, start_cont, clr_len;
  logic do_cell, do_row, do_eos, inc_line, inc_pend;
  logic any;
  logic [LEN_W:0]   sum;
  logic [LEN_W-1:0] base_len, sp;
  logic [COL_W-1:0] cells_c;

  assign fire      = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign tok_pop_o = fire;

  // Next phase and the actions this token triggers.
  always_comb begin
    phase_d    = phase_q;
    start_byte = 1'b0;
    sac_set    = 1'b0;
    sac_clr    = 1'b0;
    do_content = 1'b0;
    start_cont = 1'b0;
    clr_len    = 1'b0;
    do_cell    = 1'b0;
    do_row     = 1'b0;
    do_eos     = 1'b0;
    inc_line   = 1'b0;
    inc_pend   = 1'b0;
    if (tok_i.eos) begin
      do_eos  = 1'b1;
      phase_d = csvt_pkg::PH_LINE;
      case (phase_q)
        csvt_pkg::PH_LINE: begin
        end
        csvt_pkg::PH_COMMENT: begin
          inc_line = 1'b1;
        end
        csvt_pkg::PH_START: begin
          do_cell = sac_q;
          do_row  = 1'b1;
        end
        default: begin
          do_cell = 1'b1;
          do_row  = 1'b1;
        end
      endcase
    end else begin
      case (phase_q)
        csvt_pkg::PH_LINE: begin
          if (tok_i.is_nl) begin
            inc_line = 1'b1;
          end else if (tok_i.is_hash) begin
            phase_d = csvt_pkg::PH_COMMENT;
          end else begin
            phase_d = csvt_pkg::PH_START;
            sac_clr = 1'b1;
            if (tok_i.is_space) begin
              sac_set = 1'b1;
            end else begin
              start_byte = 1'b1;
            end
          end
        end
        csvt_pkg::PH_COMMENT: begin
          if (tok_i.is_nl) begin
            inc_line = 1'b1;
            phase_d  = csvt_pkg::PH_LINE;
          end
        end
        csvt_pkg::PH_START: begin
          start_byte = 1'b1;
        end
        csvt_pkg::PH_PLAIN: begin
          if (tok_i.is_comma) begin
            do_cell = 1'b1;
            sac_clr = 1'b1;
            phase_d = csvt_pkg::PH_START;
          end else if (tok_i.is_nl) begin
            do_cell = 1'b1;
            do_row  = 1'b1;
          end else if (tok_i.is_space) begin
            inc_pend = 1'b1;
          end else begin
            do_content = 1'b1;
          end
        end
        csvt_pkg::PH_QUOTED: begin
          if (tok_i.is_bslash) begin
            phase_d = csvt_pkg::PH_ESCAPE;
          end else if (tok_i.is_quote) begin
            phase_d = csvt_pkg::PH_AFTERQ;
          end else begin
            do_content = 1'b1;
          end
        end
        csvt_pkg::PH_ESCAPE: begin
          do_content = 1'b1;
          phase_d    = csvt_pkg::PH_QUOTED;
        end
        default: begin
          if (tok_i.is_comma) begin
            do_cell = 1'b1;
            sac_clr = 1'b1;
            phase_d = csvt_pkg::PH_START;
          end else if (tok_i.is_nl) begin
            do_cell = 1'b1;
            do_row  = 1'b1;
          end
        end
      endcase
      if (start_byte) begin
        if (tok_i.is_space) begin
          sac_set = 1'b1;
        end else if (tok_i.is_comma) begin
          do_cell = 1'b1;
          sac_clr = 1'b1;
        end else if (tok_i.is_nl) begin
          do_cell = sac_q;
          do_row  = 1'b1;
        end else if (tok_i.is_quote) begin
          clr_len = 1'b1;
          phase_d = csvt_pkg::PH_QUOTED;
        end else begin
          do_content = 1'b1;
          start_cont = 1'b1;
          phase_d    = csvt_pkg::PH_PLAIN;
        end
      end
    end
    if (do_row) begin
      phase_d = csvt_pkg::PH_LINE;
    end
  end

  // Counters, error and result fields.
  always_comb begin
    pend_d     = pend_q;
    len_d      = len_q;
    cells_d    = cells_q;
    hdr_cols_d = hdr_cols_q;
    hdr_done_d = hdr_done_q;
    sac_d      = sac_q;
    lines_d    = lines_q;
    err_d      = err_q;
    base_len   = start_cont ? '0 : len_q;
    sp         = start_cont ? '0 : pend_q;
    sum        = {1'b0, base_len} + {1'b0, sp} + (LEN_W + 1)'(1);
    cells_c    = cells_q;

    if (sac_clr) begin
      sac_d = 1'b0;
    end
    if (sac_set) begin
      sac_d = 1'b1;
    end
    if (inc_pend && (pend_q <= LEN_W'(MAX_CELL_LEN))) begin
      pend_d = pend_q + LEN_W'(1);
    end
    if (clr_len) begin
      len_d = '0;
    end
    if (do_content) begin
      pend_d = '0;
      if (sum > (LEN_W + 1)'(MAX_CELL_LEN)) begin
        len_d = LEN_W'(MAX_CELL_LEN + 1);
        if (err_q == csvt_pkg::ERR_NONE) begin
          err_d = csvt_pkg::ERR_CELL_LEN;
        end
      end else begin
        len_d = sum[LEN_W-1:0];
      end
    end
    if (do_cell) begin
      if (cells_q < COL_W'(MAX_COLUMNS)) begin
        cells_c = cells_q + COL_W'(1);
      end
      len_d  = '0;
      pend_d = '0;
    end
    cells_d = cells_c;
    if (inc_line || do_row) begin
      lines_d = lines_q + 32'd1;
    end
    if (do_row) begin
      if (cells_c != '0) begin
        if (!hdr_done_q) begin
          hdr_cols_d = cells_c;
          hdr_done_d = 1'b1;
        end else if (cells_c != hdr_cols_q && err_d == csvt_pkg::ERR_NONE) begin
          err_d = csvt_pkg::ERR_COLUMNS;
        end
      end
      cells_d = '0;
      len_d   = '0;
      pend_d  = '0;
      sac_d   = 1'b0;
    end
    if (do_eos) begin
      pend_d  = '0;
      len_d   = '0;
      cells_d = '0;
      sac_d   = 1'b0;
    end

    any = do_content || do_cell || (do_row && (cells_c != '0)) || do_eos;

    out_item_d.has_byte      = do_content;
    out_item_d.data_byte     = do_content ? tok_i.text_byte : 8'd0;
    out_item_d.spaces_before = !do_content ? 10'd0 :
        (32'(sp) > 32'(csvt_pkg::SPACES_MAX)) ? csvt_pkg::SPACES_MAX : 10'(sp);
    out_item_d.end_cell      = do_cell;
    out_item_d.end_row       = do_row && (cells_c != '0);
    out_item_d.header_row    = !hdr_done_q;
    out_item_d.cell_count    = 9'(cells_d);
    out_item_d.line_number   = lines_d;
    out_item_d.error_code    = err_d;
    out_item_d.stream_done   = do_eos;

    if (fire) begin
      out_valid_d = any;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= csvt_pkg::PH_LINE;
      pend_q      <= '0;
      len_q       <= '0;
      cells_q     <= '0;
      hdr_cols_q  <= '0;
      hdr_done_q  <= 1'b0;
      sac_q       <= 1'b0;
      lines_q     <= '0;
      err_q       <= csvt_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q    <= phase_d;
        pend_q     <= pend_d;
        len_q      <= len_d;
        cells_q    <= cells_d;
        hdr_cols_q <= hdr_cols_d;
        hdr_done_q <= hdr_done_d;
        sac_q      <= sac_d;
        lines_q    <= lines_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && any) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ src/csvt_checker.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer port checker
// Watches the top-level ports of the tokenizer over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input csvt_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input csvt_pkg::out_item_t out_item_o
);

  logic [1:0]          last_err_q;
  csvt_pkg::in_item_t  in_prev_q;
  csvt_pkg::out_item_t out_prev_q;
  logic                out_xfer;
  logic                in_hold;
  logic                in_same;
  logic                out_hold;
  logic                out_same;
  logic                no_byte;
  logic                byte_clear;
  logic                err_set;
  logic                err_same;
  logic                done_seen;
  logic                row_clear;

  assign out_xfer   = out_valid_o && !out_stall_i;
  assign in_hold    = in_valid_i && in_stall_o;
  assign in_same    = in_valid_i && (in_item_i == in_prev_q);
  assign out_hold   = out_valid_o && out_stall_i;
  assign out_same   = out_valid_o && (out_item_o == out_prev_q);
  assign no_byte    = out_valid_o && !out_item_o.has_byte;
  assign byte_clear = (out_item_o.data_byte == 8'd0) && (out_item_o.spaces_before == 10'd0);
  assign err_set    = out_valid_o && (last_err_q != csvt_pkg::ERR_NONE);
  assign err_same   = (out_item_o.error_code == last_err_q);
  assign done_seen  = out_valid_o && out_item_o.stream_done;
  assign row_clear  = (out_item_o.cell_count == 9'd0) && !out_item_o.has_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= csvt_pkg::ERR_NONE;
    end else if (out_xfer) begin
      last_err_q <= out_item_o.error_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_prev_q  <= '0;
      out_prev_q <= '0;
    end else begin
      in_prev_q  <= in_item_i;
      out_prev_q <= out_item_o;
    end
  end

  `CSVT_ASSERT_NEXT(a_in_holds, clk_i, rst_ni, in_hold, in_same, "input moved while stalled")
  `CSVT_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_hold, out_same, "output moved while stalled")
  `CSVT_ASSERT_IMPL(a_no_byte_zero, clk_i, rst_ni, no_byte, byte_clear, "data set without a byte")
  `CSVT_ASSERT_IMPL(a_error_sticky, clk_i, rst_ni, err_set, err_same, "error code changed")
  `CSVT_ASSERT_IMPL(a_done_clears_row, clk_i, rst_ni, done_seen, row_clear, "stream end left a row")

endmodule

bind csv_row_tokenizer_core csvt_checker u_csvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
